/* src/lpfr_pkg.sv */
package lpfr_pkg;

    localparam int unsigned HDR_LAST    = 3;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PAYLOAD_LIMIT = 1'b0;
    localparam t_cfg_idx CFG_COPY_LIMIT    = 1'b1;

    localparam logic [15:0] PAYLOAD_LIMIT_RST = 16'd512;
    localparam logic [15:0] COPY_LIMIT_RST    = 16'd255;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_DROP    = 1'b1
    } t_kind;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic        in_copy;
        logic        last_of_frame;
        logic [31:0] dropped_length;
    } t_result;

endpackage

/* src/lpfr_if.sv */
interface lpfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfr_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic        in_copy;
    logic        last_of_frame;
    logic [31:0] dropped_length;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output in_copy, output last_of_frame, output dropped_length,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_index,
                    input in_copy, input last_of_frame, input dropped_length,
                    output ready);
endinterface

/* src/lpfr_core.sv */
module lpfr_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  lpfr_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [lpfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                       i_accept,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_res_valid,
    output lpfr_pkg::t_result          o_res
);

    logic [15:0] r_payload_limit;
    logic [15:0] r_copy_limit;

    logic [23:0] r_hdr, n_hdr;
    logic [2:0]  r_hcnt, n_hcnt;
    logic [31:0] r_len, n_len;
    logic [31:0] r_cnt, n_cnt;
    logic        r_discard, n_discard;

    logic [31:0] w_len;
    logic [31:0] w_cnt_inc;
    logic        w_end;

    assign w_len     = {i_rx_byte, r_hdr};
    assign w_cnt_inc = r_cnt + 32'd1;
    assign w_end     = (w_cnt_inc >= r_len);

    always_comb begin
        n_hdr       = r_hdr;
        n_hcnt      = r_hcnt;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_discard   = r_discard;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_accept) begin
            if (r_hcnt < 3'(lpfr_pkg::HDR_LAST)) begin
                n_hdr  = r_hdr | (24'(i_rx_byte) << {r_hcnt[1:0], 3'b000});
                n_hcnt = r_hcnt + 3'd1;
            end else if (r_hcnt == 3'(lpfr_pkg::HDR_LAST)) begin
                if (w_len == 32'd0) begin
                    n_hdr     = '0;
                    n_hcnt    = '0;
                    n_len     = '0;
                    n_cnt     = '0;
                    n_discard = 1'b0;
                end else begin
                    n_hcnt = 3'(lpfr_pkg::HDR_LAST + 1);
                    n_len  = w_len;
                    n_cnt  = '0;
                    if (w_len > {16'd0, r_payload_limit}) begin
                        n_discard                  = 1'b1;
                        o_res_valid                = 1'b1;
                        o_res.kind                 = lpfr_pkg::KIND_DROP;
                        o_res.dropped_length       = w_len;
                    end else begin
                        n_discard = 1'b0;
                    end
                end
            end else begin
                // Payload phase: count every byte, but only emit outside a discard.
                n_cnt = w_cnt_inc;
                if (!r_discard) begin
                    o_res_valid         = 1'b1;
                    o_res.kind          = lpfr_pkg::KIND_PAYLOAD;
                    o_res.data_byte     = i_rx_byte;
                    o_res.byte_index    = r_cnt[15:0];
                    o_res.in_copy       = (r_cnt < {16'd0, r_copy_limit});
                    o_res.last_of_frame = w_end;
                end
                if (w_end) begin
                    n_hdr     = '0;
                    n_hcnt    = '0;
                    n_len     = '0;
                    n_cnt     = '0;
                    n_discard = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_limit <= lpfr_pkg::PAYLOAD_LIMIT_RST;
            r_copy_limit    <= lpfr_pkg::COPY_LIMIT_RST;
            r_hdr           <= '0;
            r_hcnt          <= '0;
            r_len           <= '0;
            r_cnt           <= '0;
            r_discard       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lpfr_pkg::CFG_PAYLOAD_LIMIT: r_payload_limit <= i_cfg_data;
                    lpfr_pkg::CFG_COPY_LIMIT:    r_copy_limit    <= i_cfg_data;
                    default: ;
                endcase
            end
            r_hdr     <= n_hdr;
            r_hcnt    <= n_hcnt;
            r_len     <= n_len;
            r_cnt     <= n_cnt;
            r_discard <= n_discard;
        end
    end

endmodule

/* src/lpfr_out_buf.sv */
module lpfr_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lpfr_pkg::t_result i_res,
    output logic              o_room,
    lpfr_out_if.source        o_res
);

    lpfr_pkg::t_result r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_count;

    logic              w_pop;
    lpfr_pkg::t_result w_head;

    // Two entries let a new request in while the previous result is still held.
    assign o_room = (r_count != 2'd2);
    assign w_pop  = o_res.valid && o_res.ready;
    assign w_head = r_mem[r_rp];

    assign o_res.valid          = (r_count != 2'd0);
    assign o_res.kind           = w_head.kind;
    assign o_res.data_byte      = w_head.data_byte;
    assign o_res.byte_index     = w_head.byte_index;
    assign o_res.in_copy        = w_head.in_copy;
    assign o_res.last_of_frame  = w_head.last_of_frame;
    assign o_res.dropped_length = w_head.dropped_length;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* src/length_prefixed_frame_receiver.sv */
// Length-prefixed frame receiver.
// i_rx carries received link bytes, one per request. Each frame starts with a
// four-byte little-endian payload length; a zero length restarts the header.
// o_res carries one result per payload byte (value, index, in-copy flag and
// last-of-frame mark) or one drop notice per frame whose length exceeds the
// payload limit; such a frame's payload is then consumed with no result.
// Header bytes and skipped bytes give no result.
// The configuration port writes payload_limit (index 0) and copy_limit
// (index 1); write them only while no frame is in progress.
// Throughput is one byte per cycle while the result buffer has room. Each result
// is written to the result buffer as its byte is taken; the per-byte decode is
// combinational, between the frame state registers and that two-entry buffer.
// When the result receiver stalls, the buffer holds up to two results and
// i_rx.ready drops only once both entries are full.
// Reset is synchronous and active low: it empties the buffer, restarts header
// collection and loads the limits with 512 and 255.
module length_prefixed_frame_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  lpfr_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [lpfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lpfr_in_if.sink                         i_rx,
    lpfr_out_if.source                      o_res
);

    logic              w_room;
    logic              w_accept;
    logic              w_res_valid;
    lpfr_pkg::t_result w_res;

    assign i_rx.ready = w_room;
    assign w_accept   = i_rx.valid && w_room;

    lpfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx.rx_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    lpfr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_room  (w_room),
        .o_res   (o_res)
    );

endmodule
